/* hdl/jpt_pkg.sv */
package jpt_pkg;

  // Longest path the position counter is sized for.
  localparam int MaxPathLen = 4096;
  localparam int PosW       = 12;
  localparam int PosCapInt  = (MaxPathLen - 1 > 4095) ? 4095 : MaxPathLen - 1;
  localparam logic [PosW-1:0] PosCap = PosW'(PosCapInt);

  // Characters with a role in the path grammar.
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChLBracket  = 8'h5B;
  localparam logic [7:0] ChRBracket  = 8'h5D;
  localparam logic [7:0] ChUnderline = 8'h5F;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // Parser modes, one-hot.
  typedef enum logic [6:0] {
    ModeExpectRoot  = 7'b0000001,
    ModeTokenStart  = 7'b0000010,
    ModeAfterDot    = 7'b0000100,
    ModeUnquoted    = 7'b0001000,
    ModeQuoted      = 7'b0010000,
    ModeAfterQuote  = 7'b0100000,
    ModeBracket     = 7'b1000000
  } mode_e;

  typedef enum logic [1:0] {
    EvByte   = 2'd0,
    EvClose  = 2'd1,
    EvAccept = 2'd2,
    EvError  = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    TtRoot  = 2'd0,
    TtField = 2'd1,
    TtIndex = 2'd2
  } tok_type_e;

  typedef enum logic [1:0] {
    ErrNoRoot     = 2'd0,
    ErrUnexpected = 2'd1,
    ErrArray      = 2'd2,
    ErrDescendant = 2'd3
  } err_code_e;

  // One result item as it waits in the output queue.
  typedef struct packed {
    ev_kind_e        kind;
    tok_type_e       ttype;
    logic [7:0]      tbyte;
    err_code_e       ecode;
    logic [PosW-1:0] epos;
    logic            last;
  } result_t;

  function automatic result_t mk_res(ev_kind_e kind, tok_type_e ttype, logic [7:0] tbyte,
                                     err_code_e ecode, logic [PosW-1:0] epos);
    result_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.tbyte = tbyte;
    r.ecode = ecode;
    r.epos  = epos;
    r.last  = 1'b0;
    return r;
  endfunction

  // Position increment that saturates at the counter cap.
  function automatic logic [PosW-1:0] pos_inc(logic [PosW-1:0] p);
    return (p >= PosCap) ? PosCap : p + 1'b1;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_field_char(logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A)) || (b == ChUnderline);
  endfunction

endpackage

/* hdl/jpt_if.sv */
// Input channel: one path byte or the end marker per transaction.
interface jpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       end_of_path;

  modport source (output valid, output path_byte, output end_of_path, input ready);
  modport sink (input valid, input path_byte, input end_of_path, output ready);
endinterface

// Output channel: one lexer event per transaction.
interface jpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [1:0]  token_type;
  logic [7:0]  token_byte;
  logic [1:0]  error_code;
  logic [11:0] error_position;
  logic        last_result;

  modport source (output valid, output event_kind, output token_type, output token_byte,
                  output error_code, output error_position, output last_result,
                  input ready);
  modport sink (input valid, input event_kind, input token_type, input token_byte,
                input error_code, input error_position, input last_result,
                output ready);
endinterface

/* hdl/json_path_tokenizer.sv */
// Channel  Modport  Payload
// in_i     sink     path_byte[8], end_of_path[1]
// out_o    source   event_kind[2], token_type[2], token_byte[8], error_code[2],
//                   error_position[12], last_result[1]
//
// One input transaction is taken per cycle while in_i.ready is high; its zero,
// one or two events enter a four-entry output queue in the same cycle and leave
// one per cycle while out_o.ready is high. The sustained rate is set by the
// output port: one event per cycle. in_i.ready is high while at most two events
// are queued, so a stalled sink stops input once three are queued. Reset empties
// the queue and returns the parser to expecting the root.
module json_path_tokenizer (
  input  logic clk_i,
  input  logic rst_ni,
  jpt_in_if.sink    in_i,
  jpt_out_if.source out_o
);
  import jpt_pkg::*;

  // Parser state.
  mode_e           mode_q, mode_d;
  logic            err_q, err_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] tstart_q, tstart_d;
  logic [1:0]      bcnt_q, bcnt_d;
  logic            bsodd_q, bsodd_d;
  logic            nondig_q, nondig_d;
  logic            empty_q, empty_d;

  // Output queue.
  result_t    fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  logic       in_acc, out_pop;
  result_t    res [2];
  logic [1:0] n_res;

  assign in_i.ready = (cnt_q <= 3'd2);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_pop    = out_o.valid && out_o.ready;

  // Lexer step for the accepted transaction.
  always_comb begin
    logic [7:0] b;
    logic       do_start;
    b        = in_i.path_byte;
    do_start = 1'b0;
    mode_d   = mode_q;
    err_d    = err_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    bcnt_d   = bcnt_q;
    bsodd_d  = bsodd_q;
    nondig_d = nondig_q;
    empty_d  = empty_q;
    res[0]   = mk_res(EvByte, TtRoot, 8'h00, ErrNoRoot, '0);
    res[1]   = res[0];
    n_res    = 2'd0;

    if (in_acc) begin
      if (in_i.end_of_path) begin
        if (!err_q) begin
          unique case (mode_q)
            ModeExpectRoot: begin
              res[0] = mk_res(EvError, TtRoot, 8'h00, ErrNoRoot, '0);
              n_res  = 2'd1;
            end
            ModeUnquoted: begin
              res[0] = mk_res(EvClose, TtField, 8'h00, ErrNoRoot, '0);
              res[1] = mk_res(EvAccept, TtRoot, 8'h00, ErrNoRoot, '0);
              n_res  = 2'd2;
            end
            ModeQuoted: begin
              res[0] = mk_res(EvError, TtRoot, 8'h00, ErrUnexpected, tstart_q);
              n_res  = 2'd1;
            end
            ModeBracket: begin
              if (empty_q || bcnt_q < 2'd2) begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrUnexpected, tstart_q);
              end else begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrArray, tstart_q);
              end
              n_res = 2'd1;
            end
            default: begin
              res[0] = mk_res(EvAccept, TtRoot, 8'h00, ErrNoRoot, '0);
              n_res  = 2'd1;
            end
          endcase
        end
        // The end marker always returns the parser to its reset state.
        mode_d   = ModeExpectRoot;
        err_d    = 1'b0;
        pos_d    = '0;
        tstart_d = '0;
        bcnt_d   = '0;
        bsodd_d  = 1'b0;
        nondig_d = 1'b0;
        empty_d  = 1'b0;
      end else begin
        if (!err_q) begin
          unique case (mode_q)
            ModeExpectRoot: begin
              if (b == ChDollar) begin
                do_start = 1'b1;
              end else begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrNoRoot, '0);
                n_res  = 2'd1;
                err_d  = 1'b1;
              end
            end
            ModeAfterDot: begin
              if (b == ChDot) begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrDescendant, tstart_q);
                n_res  = 2'd1;
                err_d  = 1'b1;
              end else begin
                do_start = 1'b1;
              end
            end
            ModeUnquoted: begin
              if (b == ChDot || b == ChLBracket) begin
                res[0]   = mk_res(EvClose, TtField, 8'h00, ErrNoRoot, '0);
                n_res    = 2'd1;
                do_start = 1'b1;
              end else if (is_field_char(b)) begin
                res[0] = mk_res(EvByte, TtField, b, ErrNoRoot, '0);
                n_res  = 2'd1;
              end else begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrUnexpected, tstart_q);
                n_res  = 2'd1;
                err_d  = 1'b1;
              end
            end
            ModeQuoted: begin
              if (b == ChQuote && !bsodd_q) begin
                res[0] = mk_res(EvClose, TtField, 8'h00, ErrNoRoot, '0);
                n_res  = 2'd1;
                mode_d = ModeAfterQuote;
              end else begin
                res[0]  = mk_res(EvByte, TtField, b, ErrNoRoot, '0);
                n_res   = 2'd1;
                bsodd_d = (b == ChBackslash) ? ~bsodd_q : 1'b0;
              end
            end
            ModeAfterQuote: begin
              if (b == ChDot || b == ChLBracket) begin
                do_start = 1'b1;
              end else begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrUnexpected, tstart_q);
                n_res  = 2'd1;
                err_d  = 1'b1;
              end
            end
            ModeBracket: begin
              if (empty_q) begin
                res[0] = mk_res(EvError, TtRoot, 8'h00, ErrArray, pos_inc(tstart_q));
                n_res  = 2'd1;
                err_d  = 1'b1;
              end else if (b == ChRBracket) begin
                if (bcnt_q == 2'd0) begin
                  empty_d = 1'b1;
                  bcnt_d  = 2'd1;
                end else if (nondig_q) begin
                  res[0] = mk_res(EvError, TtRoot, 8'h00, ErrArray, pos_inc(tstart_q));
                  n_res  = 2'd1;
                  err_d  = 1'b1;
                end else begin
                  res[0] = mk_res(EvClose, TtIndex, 8'h00, ErrNoRoot, '0);
                  n_res  = 2'd1;
                  mode_d = ModeTokenStart;
                end
              end else begin
                if (bcnt_q < 2'd2) begin
                  bcnt_d = bcnt_q + 2'd1;
                end
                if (!is_digit(b)) begin
                  nondig_d = 1'b1;
                end
                res[0] = mk_res(EvByte, TtIndex, b, ErrNoRoot, '0);
                n_res  = 2'd1;
              end
            end
            default: begin
              do_start = 1'b1;
            end
          endcase

          // Start of a new token; its events follow any close emitted above.
          if (do_start) begin
            tstart_d = pos_q;
            if (b == ChDollar) begin
              res[n_res[0]] = mk_res(EvByte, TtRoot, b, ErrNoRoot, '0);
              res[1]        = mk_res(EvClose, TtRoot, 8'h00, ErrNoRoot, '0);
              n_res         = 2'd2;
              mode_d        = ModeTokenStart;
            end else if (b == ChDot) begin
              mode_d = ModeAfterDot;
            end else if (b == ChQuote) begin
              bsodd_d = 1'b0;
              mode_d  = ModeQuoted;
            end else if (b == ChLBracket) begin
              bcnt_d   = '0;
              nondig_d = 1'b0;
              empty_d  = 1'b0;
              mode_d   = ModeBracket;
            end else if (is_field_char(b)) begin
              res[n_res[0]] = mk_res(EvByte, TtField, b, ErrNoRoot, '0);
              n_res         = n_res + 2'd1;
              mode_d        = ModeUnquoted;
            end else begin
              res[n_res[0]] = mk_res(EvError, TtRoot, 8'h00, ErrUnexpected, pos_q);
              n_res         = n_res + 2'd1;
              err_d         = 1'b1;
            end
          end
        end
        pos_d = pos_inc(pos_q);
      end
    end

    // Mark the final event of this transaction.
    if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeExpectRoot;
      err_q    <= 1'b0;
      pos_q    <= '0;
      tstart_q <= '0;
      bcnt_q   <= '0;
      bsodd_q  <= 1'b0;
      nondig_q <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      err_q    <= err_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      bcnt_q   <= bcnt_d;
      bsodd_q  <= bsodd_d;
      nondig_q <= nondig_d;
      empty_q  <= empty_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_res;
      rd_q  <= rd_q + {1'b0, out_pop};
      cnt_q <= cnt_q + {1'b0, n_res} - {2'b00, out_pop};
    end
  end

  // Queue payload, up to two writes per cycle.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_q] <= res[0];
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_q + 2'd1] <= res[1];
    end
  end

  // Head of the queue drives the output channel.
  assign out_o.valid          = (cnt_q != 3'd0);
  assign out_o.event_kind     = fifo_q[rd_q].kind;
  assign out_o.token_type     = fifo_q[rd_q].ttype;
  assign out_o.token_byte     = fifo_q[rd_q].tbyte;
  assign out_o.error_code     = fifo_q[rd_q].ecode;
  assign out_o.error_position = fifo_q[rd_q].epos;
  assign out_o.last_result    = fifo_q[rd_q].last;

endmodule
